// ===== sv/brc_pkg.sv =====
// Shared types, constants and decode functions of the bracket replacement counter.
package brc_pkg;

  localparam int unsigned STACK_ENTRIES = 4096;
  localparam int unsigned DEPTH_W       = $clog2(STACK_ENTRIES + 1);
  localparam int unsigned COUNT_W       = 16;

  localparam logic [7:0] CH_OPEN_BRACE    = 8'h7B;  // {
  localparam logic [7:0] CH_OPEN_PAREN    = 8'h28;  // (
  localparam logic [7:0] CH_OPEN_SQUARE   = 8'h5B;  // [
  localparam logic [7:0] CH_OPEN_ANGLE    = 8'h3C;  // <
  localparam logic [7:0] CH_CLOSE_BRACE   = 8'h7D;  // }
  localparam logic [7:0] CH_CLOSE_PAREN   = 8'h29;  // )
  localparam logic [7:0] CH_CLOSE_SQUARE  = 8'h5D;  // ]
  localparam logic [7:0] CH_CLOSE_ANGLE   = 8'h3E;  // >

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_BRACE  = 2'd0;
  localparam kind_t KIND_PAREN  = 2'd1;
  localparam kind_t KIND_SQUARE = 2'd2;
  localparam kind_t KIND_ANGLE  = 2'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNMATCHED = 2'd1,
    ST_UNCLOSED  = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] bracket_char;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] replacements;
    logic [1:0]         status;
  } out_t;

  // Per-cycle shift command for the row of stack cells.
  typedef struct packed {
    logic push;
    logic pop;
  } brc_cell_ctl_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } kind_dec_t;

  function automatic kind_dec_t open_decode(input logic [7:0] c);
    kind_dec_t d;
    d.hit  = 1'b1;
    d.kind = KIND_BRACE;
    case (c)
      CH_OPEN_BRACE:  d.kind = KIND_BRACE;
      CH_OPEN_PAREN:  d.kind = KIND_PAREN;
      CH_OPEN_SQUARE: d.kind = KIND_SQUARE;
      CH_OPEN_ANGLE:  d.kind = KIND_ANGLE;
      default:        d.hit  = 1'b0;
    endcase
    return d;
  endfunction

  function automatic kind_dec_t close_decode(input logic [7:0] c);
    kind_dec_t d;
    d.hit  = 1'b1;
    d.kind = KIND_BRACE;
    case (c)
      CH_CLOSE_BRACE:  d.kind = KIND_BRACE;
      CH_CLOSE_PAREN:  d.kind = KIND_PAREN;
      CH_CLOSE_SQUARE: d.kind = KIND_SQUARE;
      CH_CLOSE_ANGLE:  d.kind = KIND_ANGLE;
      default:         d.hit  = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ===== sv/brc_cell.sv =====
// One stack cell: holds a bracket kind and shifts with its neighbors on push and pop.
module brc_cell (
  input  logic                   clk,
  input  brc_pkg::brc_cell_ctl_t ctl,
  input  brc_pkg::kind_t         from_up,
  input  brc_pkg::kind_t         from_down,
  output brc_pkg::kind_t         kind_o
);
  import brc_pkg::*;

  kind_t kind_r;
  kind_t kind_nxt;

  // A push moves every entry one place deeper; a pop moves every entry one place up.
  always_comb begin
    kind_nxt = kind_r;
    if (ctl.push) begin
      kind_nxt = from_up;
    end else if (ctl.pop) begin
      kind_nxt = from_down;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  assign kind_o = kind_r;

endmodule

// ===== sv/brc_out_buf.sv =====
// Output register with a skid slot for the result channel.
module brc_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  brc_pkg::out_t res_data,
  output logic          space_ok,
  output logic          out_valid,
  input  logic          out_ready,
  output brc_pkg::out_t out_data
);
  import brc_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  out_t out_data_r, out_data_nxt;
  out_t skid_data_r, skid_data_nxt;
  logic head_free;

  // The head register can take new data when it is empty or being drained this cycle.
  assign head_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (head_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = res_valid;
        skid_data_nxt  = res_data;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt  = res_data;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign space_ok  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The skid slot only fills behind a waiting head result.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a result while the head register is empty");

  // A full skid slot never sees a new result arrive.
  a_no_skid_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_ready |-> !res_valid)
    else $error("result arrived while both output slots were full");

endmodule

// ===== sv/bracket_replace_counter_unit.sv =====
// Top level of the bracket replacement counter: control, stack cell row and output buffer.
//
// This block reads a bracket string one character per transfer on the in_ channel and,
// on the character marked last_char, produces one result transfer on the out_ channel
// with the least number of same-direction replacements that make the string a regular
// bracket sequence, plus a status (regular, unmatched closing, unclosed opening, stack
// overflow). Any byte that is not one of the eight brackets acts as a closing bracket
// that matches nothing. The stack is a row of STACK_ENTRIES small cells whose first cell
// is always the top of stack: a push shifts the whole row one place deeper and a pop
// shifts it one place up, so the block takes a new character every cycle while in_ready
// is high, with no pause between strings. The result of a string is registered and appears
// on out_valid in the cycle after its last character is transferred when no earlier
// result is still waiting; otherwise it waits in the skid slot behind that result. An
// output register plus a skid slot let input transfers continue while a result waits;
// in_ready drops only when two results are waiting. After a string's result is formed
// the depth, count and error are cleared; stack cell contents are not cleared and need
// no clearing pass, since a pop only ever reads cells that were pushed earlier in the
// same string.
module bracket_replace_counter_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  brc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output brc_pkg::out_t out_data
);
  import brc_pkg::*;

  logic [DEPTH_W-1:0] depth_r, depth_nxt, depth_after;
  logic [COUNT_W-1:0] count_r, count_nxt, count_after;
  status_t            err_r, err_nxt, err_after;

  logic          in_fire;
  logic          take;
  logic          stack_full;
  logic          stack_empty;
  logic          do_push;
  logic          do_pop;
  logic          overflow_hit;
  logic          unmatched_hit;
  logic          mismatch;
  kind_dec_t     open_dec;
  kind_dec_t     close_dec;
  brc_cell_ctl_t cell_ctl;
  kind_t         cell_kind [STACK_ENTRIES];
  status_t       res_status;
  out_t          res_data;
  logic          res_valid;

  assign in_fire = in_valid && in_ready;

  // Once a string has an error, its remaining characters are skipped.
  assign take        = in_fire && (err_r == ST_OK);
  assign open_dec    = open_decode(in_data.bracket_char);
  assign close_dec   = close_decode(in_data.bracket_char);
  assign stack_full  = (depth_r == DEPTH_W'(STACK_ENTRIES));
  assign stack_empty = (depth_r == '0);

  assign do_push       = take && open_dec.hit && !stack_full;
  assign overflow_hit  = take && open_dec.hit && stack_full;
  assign do_pop        = take && !open_dec.hit && !stack_empty;
  assign unmatched_hit = take && !open_dec.hit && stack_empty;

  // The top of stack always sits in the first cell, so the compare needs no read port.
  // A byte that is not a closing bracket never matches.
  assign mismatch = !close_dec.hit || (cell_kind[0] != close_dec.kind);

  always_comb begin
    depth_after = depth_r;
    count_after = count_r;
    err_after   = err_r;
    if (do_push) begin
      depth_after = depth_r + DEPTH_W'(1);
    end
    if (do_pop) begin
      depth_after = depth_r - DEPTH_W'(1);
      if (mismatch && (count_r != '1)) begin
        count_after = count_r + COUNT_W'(1);
      end
    end
    if (overflow_hit) begin
      err_after = ST_OVERFLOW;
    end else if (unmatched_hit) begin
      err_after = ST_UNMATCHED;
    end
  end

  // The stored error wins; otherwise a non-empty stack means an unclosed opening.
  always_comb begin
    if (err_after != ST_OK) begin
      res_status = err_after;
    end else if (depth_after != '0) begin
      res_status = ST_UNCLOSED;
    end else begin
      res_status = ST_OK;
    end
    res_data.status       = res_status;
    res_data.replacements = (res_status == ST_OK) ? count_after : '0;
  end

  assign res_valid = in_fire && in_data.last_char;

  // A string's end clears the per-string state for the next string.
  always_comb begin
    if (res_valid) begin
      depth_nxt = '0;
      count_nxt = '0;
      err_nxt   = ST_OK;
    end else begin
      depth_nxt = depth_after;
      count_nxt = count_after;
      err_nxt   = err_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      count_r <= '0;
      err_r   <= ST_OK;
    end else begin
      depth_r <= depth_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  assign cell_ctl.push = do_push;
  assign cell_ctl.pop  = do_pop;

  // Row of stack cells. The first cell takes the pushed kind; the deepest cell holds
  // its value on a pop, since nothing lies below it.
  for (genvar i = 0; i < STACK_ENTRIES; i++) begin : g_cell
    kind_t up_kind;
    kind_t down_kind;
    if (i == 0) begin : g_first
      assign up_kind = open_dec.kind;
    end else begin : g_inner_up
      assign up_kind = cell_kind[i-1];
    end
    if (i == STACK_ENTRIES - 1) begin : g_last
      assign down_kind = cell_kind[i];
    end else begin : g_inner_down
      assign down_kind = cell_kind[i+1];
    end
    brc_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .from_up   (up_kind),
      .from_down (down_kind),
      .kind_o    (cell_kind[i])
    );
  end

  brc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The depth never runs past the number of cells.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_ENTRIES))
    else $error("stack depth beyond the cell count");

  // The end of a string leaves clean per-string state behind.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (depth_r == '0) && (count_r == '0) && (err_r == ST_OK))
    else $error("per-string state not cleared after the last character");

  // An error sticks, and freezes the stack, until the string ends.
  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK) && !res_valid |=> (err_r == $past(err_r)) && $stable(depth_r))
    else $error("error or depth changed while the string was in error");

  // A result that is not regular carries no replacement count.
  a_count_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res_data.status != ST_OK) |-> (res_data.replacements == '0))
    else $error("non-zero count on a string that is not regular");

endmodule
